/* rtl/tce_pkg.sv */
package tce_pkg;

  // Screen geometry
  localparam int COLUMNS  = 80;
  localparam int ROWS     = 25;
  localparam int TAB_STOP = 8;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int ADDR_W   = $clog2(CELLS);

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int LOC_W  = 11;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_GOTO  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // Outcome of one put-character step
  typedef struct packed {
    logic             wr;
    logic             scroll;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } put_res_t;

  // Next tab stop for every column value
  typedef logic [COL_W:0] tab_tbl_t [2**COL_W];

  function automatic tab_tbl_t build_tab();
    tab_tbl_t t;
    for (int i = 0; i < 2**COL_W; i++) begin
      t[i] = (COL_W+1)'((i / TAB_STOP + 1) * TAB_STOP);
    end
    return t;
  endfunction

  localparam tab_tbl_t TAB_NEXT = build_tab();

  // Linear cell index of a row and column
  function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
    return ADDR_W'(int'(r) * COLUMNS + int'(c));
  endfunction

  function automatic logic [LOC_W-1:0] cursor_loc(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return LOC_W'(int'(r) * COLUMNS + int'(c));
  endfunction

endpackage

/* rtl/tce_cursor.sv */
module tce_cursor import tce_pkg::*; (
  input  logic [COL_W-1:0]  col_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [CHAR_W-1:0] char_i,
  output put_res_t          put_o
);

  logic [COL_W:0] col_n;
  logic [ROW_W:0] row_n;
  logic           wr;
  logic           scroll;

  always_comb begin
    col_n  = {1'b0, col_i};
    row_n  = {1'b0, row_i};
    wr     = 1'b0;
    scroll = 1'b0;

    // Interpret control bytes, store printable ones
    priority if (char_i == CH_BS) begin
      if (col_i != '0) col_n = col_n - (COL_W+1)'(1);
    end else if (char_i == CH_TAB) begin
      col_n = TAB_NEXT[col_i];
    end else if (char_i == CH_CR) begin
      col_n = '0;
    end else if (char_i == CH_LF) begin
      col_n = '0;
      row_n = row_n + (ROW_W+1)'(1);
    end else if (char_i >= CH_SPACE) begin
      wr    = 1'b1;
      col_n = col_n + (COL_W+1)'(1);
    end else begin
      wr = 1'b0;
    end

    // Wrap at the end of a row
    if (32'(col_n) >= COLUMNS) begin
      col_n = '0;
      row_n = row_n + (ROW_W+1)'(1);
    end

    // Past the last row: scroll and park on the bottom row
    if (32'(row_n) >= ROWS) begin
      scroll = 1'b1;
      row_n  = (ROW_W+1)'(ROWS - 1);
    end
  end

  assign put_o.wr     = wr;
  assign put_o.scroll = scroll;
  assign put_o.col    = col_n[COL_W-1:0];
  assign put_o.row    = row_n[ROW_W-1:0];

endmodule

/* rtl/text_console_engine_unit.sv */
// Channel  | Signals                                         | Transaction
// ---------+-------------------------------------------------+---------------------------
// command  | start_i, busy_o, cmd_i, char_code_i, col_i,     | start_i high, busy_o low
//          | row_i, clear_attr_i                             |
// result   | done_o, cursor_col_o, cursor_row_o,             | done_o high for one cycle
//          | cursor_location_o, cell_value_o                 |
// config   | cfg_valid_i, cfg_ready_o, cfg_data_i            | cfg_valid_i and cfg_ready_o
//
// For put character without a scroll and for goto, done_o follows in the next cycle.
// Read cell waits in S_READ for the registered read port of the screen memory.
// A scroll runs one copy per cycle through the single write port, then fills the bottom
// row with blanks; clear screen fills every cell.
// After reset a clearing pass zeroes every cell of the memory with busy_o high.
// The receiver cannot stall: every result is taken in its done_o cycle.
module text_console_engine_unit import tce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        cmd_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [7:0]        clear_attr_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i,
  output logic              done_o,
  output logic [COL_W-1:0]  cursor_col_o,
  output logic [ROW_W-1:0]  cursor_row_o,
  output logic [LOC_W-1:0]  cursor_location_o,
  output logic [CELL_W-1:0] cell_value_o
);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_IDLE   = 6'b000010,
    S_READ   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_FILL   = 6'b010000,
    S_SPARE  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [7:0]        text_color_q;
  logic [CELL_W-1:0] fill_q, fill_d;
  logic              rd_ok_q, rd_ok_d;
  logic              done_q, done_d;
  logic [CELL_W-1:0] cell_d;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [LOC_W-1:0]  out_loc_q;
  logic [CELL_W-1:0] out_cell_q;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic [CELL_W-1:0] screen_q [CELLS];
  logic [CELL_W-1:0] rdata_q;

  put_res_t          put;

  tce_cursor u_cursor (
    .col_i  (cur_col_q),
    .row_i  (cur_row_q),
    .char_i (char_code_i),
    .put_o  (put)
  );

  // Screen memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) screen_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= screen_q[mem_raddr];
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    fill_d    = fill_q;
    rd_ok_d   = rd_ok_q;
    done_d    = 1'b0;
    cell_d    = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        if (addr_q == ADDR_W'(CELLS - 1)) begin
          addr_d  = '0;
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end

      S_IDLE: begin
        if (start_i) begin
          unique case (cmd_e'(cmd_i))
            CMD_PUT: begin
              mem_we    = put.wr;
              mem_waddr = cell_index(cur_row_q, cur_col_q);
              mem_wdata = {text_color_q, char_code_i};
              cur_col_d = put.col;
              cur_row_d = put.row;
              if (put.scroll) begin
                addr_d  = '0;
                state_d = S_SCROLL;
              end else begin
                done_d = 1'b1;
              end
            end
            CMD_GOTO: begin
              if (32'(col_i) < COLUMNS) cur_col_d = col_i;
              if (32'(row_i) < ROWS) cur_row_d = row_i;
              done_d = 1'b1;
            end
            CMD_CLEAR: begin
              fill_d    = {clear_attr_i, CH_SPACE};
              addr_d    = '0;
              cur_col_d = '0;
              cur_row_d = '0;
              state_d   = S_FILL;
            end
            CMD_READ: begin
              rd_ok_d   = (32'(col_i) < COLUMNS) && (32'(row_i) < ROWS);
              mem_re    = 1'b1;
              mem_raddr = cell_index(row_i, col_i);
              state_d   = S_READ;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_READ: begin
        done_d  = 1'b1;
        cell_d  = rd_ok_q ? rdata_q : '0;
        state_d = S_IDLE;
      end

      // Copy each cell below the top row one row up: read ahead, write back in the next cycle
      S_SCROLL: begin
        if (addr_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = addr_q - ADDR_W'(1);
          mem_wdata = rdata_q;
        end
        if (addr_q == ADDR_W'(CELLS - COLUMNS)) begin
          fill_d  = {text_color_q, CH_SPACE};
          state_d = S_FILL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = addr_q + ADDR_W'(COLUMNS);
          addr_d    = addr_q + ADDR_W'(1);
        end
      end

      // Fill from the current address through the last cell
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = fill_q;
        if (addr_q == ADDR_W'(CELLS - 1)) begin
          addr_d  = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          addr_d = addr_q + ADDR_W'(1);
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      addr_q       <= '0;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      text_color_q <= '0;
      rd_ok_q      <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      state_q   <= state_d;
      addr_q    <= addr_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      rd_ok_q   <= rd_ok_d;
      done_q    <= done_d;
      if (cfg_valid_i) text_color_q <= cfg_data_i;
    end
  end

  // Fill word and result payload
  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
    if (done_d) begin
      out_col_q  <= cur_col_d;
      out_row_q  <= cur_row_d;
      out_loc_q  <= cursor_loc(cur_row_d, cur_col_d);
      out_cell_q <= cell_d;
    end
  end

  assign busy_o            = (state_q != S_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign done_o            = done_q;
  assign cursor_col_o      = out_col_q;
  assign cursor_row_o      = out_row_q;
  assign cursor_location_o = out_loc_q;
  assign cell_value_o      = out_cell_q;

endmodule
